// ===== hw/rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// Fenwick prefix-sum engine package
// Sizes, operation codes and the command and status records shared by the
// engine's modules and channel interfaces.
// ----------------------------------------------------------------------------
package fps_pkg;

   // Number of tree nodes; node zero is never used.
   localparam int TREE_SIZE = 1024;

   // Node address width and walk position width (one bit more, so that an
   // upward walk can step past the last node).
   localparam int ADDR_W = $clog2(TREE_SIZE);
   localparam int POS_W  = ADDR_W + 1;

   // Fixed field widths of the channels.
   localparam int OP_W    = 2;
   localparam int INDEX_W = 10;
   localparam int SUM_W   = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_PREFIX = 2'd1;
   localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;

   // Command from the channel front end to the walk core.
   typedef struct packed {
      logic              start;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] hi;
      logic [ADDR_W-1:0] lo;
      logic [SUM_W-1:0]  delta;
   } fps_cmd_type;

   // Status from the walk core to the front end.
   typedef struct packed {
      logic             idle;
      logic             done;
      logic [SUM_W-1:0] sum;
   } fps_stat_type;

endpackage

// ===== hw/rtl/fps_if.sv =====
// ----------------------------------------------------------------------------
// Fenwick prefix-sum engine channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface fps_req_if;
   import fps_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OP_W-1:0]             op;
   logic [INDEX_W-1:0]          index;
   logic [INDEX_W-1:0]          low_index;
   logic signed [SUM_W-1:0]     delta;

   modport source (output valid, output op, output index, output low_index,
                   output delta, input ready);
   modport sink   (input valid, input op, input index, input low_index,
                   input delta, output ready);
endinterface

interface fps_rsp_if;
   import fps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum;

   modport source (output valid, output sum, input ready);
   modport sink   (input valid, input sum, output ready);
endinterface

// ===== hw/rtl/fps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/fps_core.sv =====
// ----------------------------------------------------------------------------
// Fenwick prefix-sum walk core
// Clears the node store after reset, then walks the tree for each command:
// upward read-modify-write for an add, downward accumulation for a prefix,
// and two downward walks for a range (one when its low index is zero).
// ----------------------------------------------------------------------------
module fps_core (
   input  logic                  clock,
   input  logic                  reset,
   input  fps_pkg::fps_cmd_type  cmd,
   input  logic                  out_free,
   output fps_pkg::fps_stat_type stat
);
   import fps_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              add_mode_ff, add_mode_in;
   logic              sub_ff, sub_in;
   logic              second_ff, second_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [SUM_W-1:0]  rd_data;
   logic [POS_W-1:0]  pos_lsb;
   logic              walk_more;
   logic              done;

   // Node store.
   fps_ram #(
      .WIDTH (SUM_W),
      .DEPTH (TREE_SIZE)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Lowest set bit of the walk position, and whether the walk goes on.
   assign pos_lsb   = pos_ff & (~pos_ff + POS_W'(1));
   assign walk_more = add_mode_ff ? ((pos_ff != '0) && (pos_ff < POS_W'(TREE_SIZE)))
                                  : (pos_ff != '0);

   // Next-state and memory control. A node is read in one cycle and its data
   // is used in the next, while the following node is read; the addresses of
   // one walk never repeat, so no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      add_mode_in  = add_mode_ff;
      sub_in       = sub_ff;
      second_in    = second_ff;
      pend_vld_in  = pend_vld_ff;
      pend_addr_in = pend_addr_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff[ADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data + delta_ff;
      done         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(TREE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (cmd.start) begin
               acc_in      = '0;
               delta_in    = cmd.delta;
               lo_in       = cmd.lo;
               sub_in      = 1'b0;
               pend_vld_in = 1'b0;
               pos_in      = POS_W'(cmd.hi);
               unique case (cmd.op)
                  OP_ADD: begin
                     add_mode_in = 1'b1;
                     second_in   = 1'b0;
                     state_in    = ST_WALK;
                  end
                  OP_PREFIX: begin
                     add_mode_in = 1'b0;
                     second_in   = 1'b0;
                     state_in    = ST_WALK;
                  end
                  OP_RANGE: begin
                     add_mode_in = 1'b0;
                     second_in   = (cmd.lo != '0);
                     state_in    = ST_WALK;
                  end
                  default: begin
                     // Unused code: no walk, the sum stays zero.
                     add_mode_in = 1'b0;
                     second_in   = 1'b0;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Issue the read of the current node and step the position.
            if (walk_more) begin
               rd_en        = 1'b1;
               pend_vld_in  = 1'b1;
               pend_addr_in = pos_ff[ADDR_W-1:0];
               pos_in       = add_mode_ff ? (pos_ff + pos_lsb) : (pos_ff - pos_lsb);
            end else begin
               pend_vld_in = 1'b0;
            end

            // Use the node read in the previous cycle.
            if (pend_vld_ff) begin
               if (add_mode_ff) begin
                  wr_en = 1'b1;
               end else begin
                  acc_in = sub_ff ? (acc_ff - rd_data) : (acc_ff + rd_data);
               end
            end

            // Walk finished: start the lower prefix of a range, or finish.
            if (!walk_more && !pend_vld_ff) begin
               if (second_ff) begin
                  second_in = 1'b0;
                  sub_in    = 1'b1;
                  pos_in    = POS_W'(lo_ff - ADDR_W'(1));
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_vld_ff <= pend_vld_in;
      end
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      add_mode_ff  <= add_mode_in;
      sub_ff       <= sub_in;
      second_ff    <= second_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = done;
   assign stat.sum  = acc_ff;

   // A write and a read never hit the same node in one cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("node read and write collide");

   // Every node read during an add walk is written back in the next cycle.
   a_add_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && add_mode_ff && rd_en) |=>
         (wr_en && wr_addr == $past(rd_addr)))
      else $error("add walk lost a write-back");

   // The clearing pass reads nothing and takes no command.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rd_en && !stat.idle))
      else $error("activity during clearing pass");

   // A finished result returns the core to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> stat.idle)
      else $error("core not idle after result");

endmodule

// ===== hw/rtl/fenwick_prefix_sum_engine.sv =====
// ----------------------------------------------------------------------------
// Fenwick prefix-sum engine
// Binary indexed tree of wrapping 32-bit partial sums with add, prefix-sum
// and range-sum operations.
// ----------------------------------------------------------------------------
// Request beats on req_ch carry op (0 add, 1 prefix, 2 range), index (the
// upper end for a range), low_index and delta. Every request gives exactly
// one response beat on rsp_ch: the prefix or range sum, or zero for an add
// or the unused code. Indexes at or above the tree size go to the last node.
// After reset the node store is cleared, one node per cycle, through all
// TREE_SIZE (1024) nodes; req_ch.ready stays low during that pass.
// One request is worked at a time. A walk reads one node per cycle, then
// uses the last read and closes the walk; the result then passes from the
// core into the output register. A range walks the upper prefix and then
// the lower one, which has at most ADDR_W - 1 nodes. req_ch.ready rises
// again in the same cycle as the response turns valid.
// While the receiver stalls, the next request is still accepted and worked;
// its result waits in the core until the output register frees.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_engine (
   input  logic      clock,
   input  logic      reset,
   fps_req_if.sink   req_ch,
   fps_rsp_if.source rsp_ch
);
   import fps_pkg::*;

   fps_cmd_type       cmd;
   fps_stat_type      stat;
   logic              out_free;
   logic [ADDR_W-1:0] hi_clamped;
   logic [ADDR_W-1:0] lo_clamped;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   // Saturate both indexes to the last node.
   always_comb begin
      if (32'(req_ch.index) >= 32'(TREE_SIZE)) begin
         hi_clamped = ADDR_W'(TREE_SIZE - 1);
      end else begin
         hi_clamped = ADDR_W'(req_ch.index);
      end
      if (32'(req_ch.low_index) >= 32'(TREE_SIZE)) begin
         lo_clamped = ADDR_W'(TREE_SIZE - 1);
      end else begin
         lo_clamped = ADDR_W'(req_ch.low_index);
      end
   end

   // Request side: a beat is taken whenever the core is idle.
   assign req_ch.ready = stat.idle;
   assign cmd.start    = req_ch.valid && stat.idle;
   assign cmd.op       = req_ch.op;
   assign cmd.hi       = hi_clamped;
   assign cmd.lo       = lo_clamped;
   assign cmd.delta    = $unsigned(req_ch.delta);

   fps_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .out_free (out_free),
      .stat     (stat)
   );

   // Response register: loads a finished sum when empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = stat.done || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_sum_in   = stat.done ? stat.sum : rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.sum   = $signed(rsp_sum_ff);

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Fenwick prefix-sum engine testbench
// Drives add, prefix-sum, range-sum and unused-code request beats into the
// engine and checks each response beat against a predictor that keeps its
// own copy of the binary indexed tree. The test tasks cover corner cases,
// random traffic with idle cycles on both channels, a stretch without idle
// cycles, and a pause until every outstanding response has come back.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fps_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 30;
   // Clear pass, then about 625 beats of worst-case walks plus
   // sender gaps and receiver stalls, taken several times over.
   localparam int CYCLE_LIMIT = 200_000;

   // The fourth op code has no package name; the engine treats it as a no-op.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Last node and middle node as request indexes.
   localparam logic [INDEX_W-1:0] LAST_NODE = INDEX_W'(TREE_SIZE - 1);
   localparam logic [INDEX_W-1:0] MID_NODE  = INDEX_W'(TREE_SIZE / 2);

   logic clock;
   logic reset;

   fps_req_if req_ch ();
   fps_rsp_if rsp_ch ();

   fenwick_prefix_sum_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: partial sums per node, node zero unused.
   logic [SUM_W-1:0]        tree_sums [TREE_SIZE];
   logic signed [SUM_W-1:0] pending_sums [$];
   logic signed [SUM_W-1:0] oldest_sum;

   bit idling_on = 1'b1;
   int mismatch_count = 0;
   int sums_checked = 0;
   int add_count = 0;
   int prefix_count = 0;
   int range_count = 0;
   int unused_count = 0;
   int cycle_count = 0;

   // Clock generation.
   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Index saturation to the last node.
   function automatic int unsigned clamp_node(input logic [INDEX_W-1:0] v);
      return (v >= TREE_SIZE) ? TREE_SIZE - 1 : v;
   endfunction

   // Downward walk: sum of the nodes that cover 1..pos.
   function automatic logic [SUM_W-1:0] tree_prefix(input int unsigned pos);
      logic [SUM_W-1:0] acc;
      int unsigned p;
      acc = '0;
      p = pos;
      while (p > 0) begin
         if (p < TREE_SIZE) acc += tree_sums[p];
         p -= p & (~p + 1);
      end
      return acc;
   endfunction

   // Applies one accepted request to the tree copy and returns its sum.
   function automatic logic [SUM_W-1:0] apply_request(
      input logic [OP_W-1:0]    op,
      input logic [INDEX_W-1:0] index,
      input logic [INDEX_W-1:0] low_index,
      input logic [SUM_W-1:0]   delta
   );
      int unsigned hi;
      int unsigned lo;
      int unsigned p;
      logic [SUM_W-1:0] below;
      hi = clamp_node(index);
      lo = clamp_node(low_index);
      case (op)
         OP_ADD: begin
            // An add at node zero would never climb, so it is dropped.
            p = hi;
            if (p != 0) begin
               while (p < TREE_SIZE) begin
                  tree_sums[p] += delta;
                  p += p & (~p + 1);
               end
            end
            return '0;
         end
         OP_PREFIX: begin
            return tree_prefix(hi);
         end
         OP_RANGE: begin
            // A range starting at zero has no lower prefix; lo > hi wraps.
            below = (lo == 0) ? '0 : tree_prefix(lo - 1);
            return tree_prefix(hi) - below;
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   // Sends one request beat, idling at random first, and records its sum.
   task automatic send_request(
      input logic [OP_W-1:0]       op,
      input logic [INDEX_W-1:0]    index,
      input logic [INDEX_W-1:0]    low_index,
      input logic signed [SUM_W-1:0] delta
   );
      logic signed [SUM_W-1:0] expected_sum;
      while (idling_on && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.index     <= index;
      req_ch.low_index <= low_index;
      req_ch.delta     <= delta;
      do @(posedge clock); while (!req_ch.ready);
      expected_sum = apply_request(op, index, low_index, delta);
      pending_sums = {pending_sums, expected_sum};
      case (op)
         OP_ADD:    add_count++;
         OP_PREFIX: prefix_count++;
         OP_RANGE:  range_count++;
         default:   unused_count++;
      endcase
   endtask

   // Drops valid and waits until every outstanding response has arrived.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
   endtask

   // Index that leans on the ends and on a power of two now and then.
   function automatic logic [INDEX_W-1:0] pick_index();
      case ($urandom_range(19))
         0:       return '0;
         1:       return INDEX_W'(1);
         2:       return LAST_NODE;
         3:       return MID_NODE;
         default: return INDEX_W'($urandom_range(TREE_SIZE - 1));
      endcase
   endfunction

   // One random request: mostly adds and queries, a few unused codes.
   task automatic send_random_request();
      int pick;
      logic [OP_W-1:0]       op;
      logic [INDEX_W-1:0]    hi;
      logic [INDEX_W-1:0]    lo;
      logic signed [SUM_W-1:0] delta;
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_ADD;
      else if (pick < 65) op = OP_PREFIX;
      else if (pick < 95) op = OP_RANGE;
      else                op = OP_UNUSED;
      hi = pick_index();
      // Most ranges are ordered; the rest are reversed or arbitrary.
      lo = ($urandom_range(4) != 0) ? INDEX_W'($urandom_range(hi)) : pick_index();
      delta = $urandom_range(1) ? $urandom : int'($urandom_range(200)) - 100;
      send_request(op, hi, lo, delta);
   endtask

   // Corner cases: empty tree, add at node zero, extreme deltas and indexes,
   // range from zero, reversed ranges and the unused code.
   task automatic test_corner_items();
      send_request(OP_PREFIX, LAST_NODE, 0, 0);
      send_request(OP_ADD, 0, 0, 12345);
      send_request(OP_PREFIX, LAST_NODE, 0, 0);
      send_request(OP_ADD, 1, 0, 32'sh7FFF_FFFF);
      send_request(OP_ADD, LAST_NODE, LAST_NODE, 32'sh8000_0000);
      send_request(OP_ADD, MID_NODE, 0, 7);
      send_request(OP_ADD, 1, 0, 1);
      send_request(OP_PREFIX, 0, 0, 0);
      send_request(OP_PREFIX, 1, 0, 0);
      send_request(OP_PREFIX, MID_NODE - INDEX_W'(1), 0, 0);
      send_request(OP_PREFIX, MID_NODE, 0, 0);
      send_request(OP_PREFIX, LAST_NODE - INDEX_W'(1), 0, 0);
      send_request(OP_PREFIX, LAST_NODE, 0, 0);
      send_request(OP_RANGE, LAST_NODE, 0, 0);
      send_request(OP_RANGE, 1, 1, 0);
      send_request(OP_RANGE, 0, LAST_NODE, 0);
      send_request(OP_RANGE, MID_NODE - INDEX_W'(1), MID_NODE + INDEX_W'(1), 0);
      send_request(OP_UNUSED, LAST_NODE, LAST_NODE, -1);
      send_request(OP_PREFIX, LAST_NODE, 0, 0);
      send_request(OP_ADD, LAST_NODE, 0, -1);
      send_request(OP_ADD, 768, 0, 32'sh5555_5555);
      send_request(OP_ADD, 341, 0, 32'shAAAA_AAAA);
      send_request(OP_RANGE, LAST_NODE, MID_NODE, 0);
      send_request(OP_RANGE, LAST_NODE, LAST_NODE, 0);
   endtask

   // Random traffic with idle cycles on both channels.
   task automatic test_random_traffic(input int count);
      idling_on = 1'b1;
      repeat (count) send_random_request();
   endtask

   // Random traffic with no idle cycles on either side.
   task automatic test_back_to_back(input int count);
      idling_on = 1'b0;
      repeat (count) send_random_request();
      idling_on = 1'b1;
   endtask

   // Random traffic with a full drain after the first tenth of the beats.
   task automatic test_drain_then_resume(input int count);
      idling_on = 1'b1;
      repeat (count / 10) send_random_request();
      wait_for_drain();
      repeat (count - count / 10) send_random_request();
   endtask

   // Response checker; the receiver stalls at random while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_sums.size() == 0) begin
               $error("Response beat with no request outstanding: sum %0d", rsp_ch.sum);
               mismatch_count++;
            end else begin
               oldest_sum = pending_sums.pop_front();
               sums_checked++;
               if (rsp_ch.sum !== oldest_sum) begin
                  $error("Field sum: expected %0d, actual %0d", oldest_sum, rsp_ch.sum);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= !(idling_on && $urandom_range(99) < 14);
      end
   end

   // Run limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Test sequence.
   initial begin
      foreach (tree_sums[i]) tree_sums[i] = '0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= OP_ADD;
      req_ch.index     <= '0;
      req_ch.low_index <= '0;
      req_ch.delta     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_items();
      test_random_traffic(250);
      test_back_to_back(150);
      test_drain_then_resume(200);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d adds, %0d prefix sums, %0d range sums, %0d unused-code beats.",
               add_count, prefix_count, range_count, unused_count);
      $display("Compared %0d response beats against the tree predictor.", sums_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
